// ===== src/dsc_pkg.sv =====
// Shared constants and types for the distinct subsequence counter.
// No dependencies; imported by every module of the block except dsc_ram.
`timescale 1ns / 1ps

package dsc_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int COUNT_W     = 60;
    localparam int SYM_W       = 8;
    localparam int MODE_W      = 2;

    localparam logic [COUNT_W-1:0] COUNT_MODULUS = 60'd1000000000000000000;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEXT   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_FETCH,
        S_READ,
        S_UPD,
        S_DONE
    } dsc_state_t;

endpackage

// ===== src/distinct_subsequence_counter.sv =====
// Distinct subsequence counter, top level.
// Depends on dsc_pkg, dsc_ram and dsc_add_mod.
//
// Usage: one input channel (mode, symbol) and one result channel
// (match_count, pattern_full), both valid/ready. Every input item gives
// exactly one result item.
// Mode 0 clears the pattern, mode 1 appends a pattern byte (clearing the
// counts), mode 2 feeds a text byte, mode 3 does nothing. Clear, append and
// mode 3 finish in one cycle: the result is shown the cycle after the item,
// so such items can follow one per cycle while results are taken.
// A text byte walks the pattern from its last position down to the first
// through one modular adder, the partial counts sitting in a RAM with a
// registered read; the states are S_PRIME and S_FETCH, then S_UPD for each
// position with S_READ between, then S_DONE, which loads the result.
// An empty pattern answers a text byte in the cycle after the item.
// in_ready is low while an item is being worked on and while the result
// register is full and out_ready is low; a stalled result holds its value.
// Reset empties the pattern, marks all partial counts as zero (valid bits)
// and drops any pending result; no clearing pass is needed.
`timescale 1ns / 1ps

module distinct_subsequence_counter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dsc_pkg::MODE_W-1:0]   mode,
    input  logic [dsc_pkg::SYM_W-1:0]    symbol,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dsc_pkg::COUNT_W-1:0]  match_count,
    output logic                         pattern_full
);
    import dsc_pkg::*;

    dsc_state_t             state_reg, state_next;
    logic [IDX_W-1:0]       k_reg, k_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [SYM_W-1:0]       sym_reg, sym_next;
    logic [SYM_W-1:0]       pat_reg [MAX_PATTERN];
    logic [SYM_W-1:0]       pat_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cnt_valid_reg, cnt_valid_next;
    logic                   rd_valid_reg;
    logic [COUNT_W-1:0]     upper_reg, upper_next;
    logic [COUNT_W-1:0]     whole_reg, whole_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;
    logic                   out_full_reg, out_full_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [COUNT_W-1:0]     ram_rdata;
    logic [COUNT_W-1:0]     rd_count;
    logic [COUNT_W-1:0]     lower;
    logic [COUNT_W-1:0]     add_sum;
    logic [LEN_W-1:0]       len_m1;
    logic                   accept;
    logic                   slot_free;

    dsc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_PATTERN)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (k_reg),
        .wdata (add_sum),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dsc_add_mod u_add (
        .a   (upper_reg),
        .b   (lower),
        .sum (add_sum)
    );

    assign rd_count  = rd_valid_reg ? ram_rdata : '0;
    assign lower     = (k_reg == '0) ? COUNT_W'(1) : rd_count;
    assign len_m1    = len_reg - 1'b1;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    assign out_valid    = out_valid_reg;
    assign match_count  = out_count_reg;
    assign pattern_full = out_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            cnt_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            whole_reg     <= COUNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_valid_reg <= cnt_valid_next;
            rd_valid_reg  <= cnt_valid_reg[ram_raddr];
            whole_reg     <= whole_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        sym_reg       <= sym_next;
        pat_reg       <= pat_next;
        upper_reg     <= upper_next;
        out_count_reg <= out_count_next;
        out_full_reg  <= out_full_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        sym_next       = sym_reg;
        pat_next       = pat_reg;
        cnt_valid_next = cnt_valid_reg;
        upper_next     = upper_reg;
        whole_next     = whole_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_count_next = out_count_reg;
        out_full_next  = out_full_reg;
        ram_we         = 1'b0;
        ram_raddr      = k_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_CLEAR:
                        begin
                            len_next       = '0;
                            cnt_valid_next = '0;
                            whole_next     = COUNT_W'(1);
                            out_valid_next = 1'b1;
                            out_count_next = COUNT_W'(1);
                            out_full_next  = 1'b0;
                        end
                        MODE_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            if (len_reg == LEN_W'(MAX_PATTERN))
                            begin
                                out_count_next = whole_reg;
                                out_full_next  = 1'b1;
                            end
                            else
                            begin
                                pat_next[len_reg[IDX_W-1:0]] = symbol;
                                len_next       = len_reg + 1'b1;
                                cnt_valid_next = '0;
                                whole_next     = '0;
                                out_count_next = '0;
                                out_full_next  = 1'b0;
                            end
                        end
                        MODE_TEXT:
                        begin
                            if (len_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_count_next = whole_reg;
                                out_full_next  = 1'b0;
                            end
                            else
                            begin
                                sym_next   = symbol;
                                k_next     = len_m1[IDX_W-1:0];
                                state_next = S_PRIME;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_count_next = whole_reg;
                            out_full_next  = 1'b0;
                        end
                    endcase
                end
            end
            S_PRIME:
            begin
                ram_raddr  = k_reg;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                upper_next = rd_count;
                ram_raddr  = k_reg - 1'b1;
                state_next = S_UPD;
            end
            S_READ:
            begin
                ram_raddr  = k_reg - 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (pat_reg[k_reg] == sym_reg)
                begin
                    ram_we                = 1'b1;
                    cnt_valid_next[k_reg] = 1'b1;
                    if (k_reg == len_m1[IDX_W-1:0])
                    begin
                        whole_next = add_sum;
                    end
                end
                upper_next = lower;
                if (k_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = whole_reg;
                    out_full_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/dsc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/dsc_add_mod.sv =====
// Shared modular adder: (a + b) mod 10^18 for operands below the modulus.
// Depends on dsc_pkg.
`timescale 1ns / 1ps

module dsc_add_mod (
    input  logic [dsc_pkg::COUNT_W-1:0] a,
    input  logic [dsc_pkg::COUNT_W-1:0] b,
    output logic [dsc_pkg::COUNT_W-1:0] sum
);
    import dsc_pkg::*;

    logic [COUNT_W:0] raw;

    always_comb
    begin
        raw = {1'b0, a} + {1'b0, b};
        if (raw >= {1'b0, COUNT_MODULUS})
        begin
            sum = COUNT_W'(raw - {1'b0, COUNT_MODULUS});
        end
        else
        begin
            sum = raw[COUNT_W-1:0];
        end
    end

endmodule

// ===== src/dsc_checker.sv =====
// Port-level checks for the distinct subsequence counter, bound to the top.
// Depends on dsc_pkg and distinct_subsequence_counter.
`timescale 1ns / 1ps

module dsc_props (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [dsc_pkg::MODE_W-1:0]   mode,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [dsc_pkg::COUNT_W-1:0]  match_count,
    input logic                         pattern_full
);
    import dsc_pkg::*;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> match_count < COUNT_MODULUS)
        else $error("match_count not reduced");

    a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("item taken while result stalled");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode == MODE_CLEAR) |=>
            (out_valid && match_count == COUNT_W'(1) && !pattern_full))
        else $error("clear did not report one");

    a_append_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode == MODE_APPEND) |=>
            (out_valid && (pattern_full || match_count == '0)))
        else $error("append did not report cleared count or full");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(match_count)))
        else $error("stalled result changed");

endmodule

bind distinct_subsequence_counter dsc_props u_dsc_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_count  (match_count),
    .pattern_full (pattern_full)
);

// ===== dv/dsc_checker.sv =====
// Checker for the distinct subsequence counter: watches both channels, keeps its
// own copy of the pattern and partial counts, and compares every result item.
// Depends on dsc_pkg.
`timescale 1ns / 1ps

module dsc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [dsc_pkg::MODE_W-1:0]   mode,
    input  logic [dsc_pkg::SYM_W-1:0]    symbol,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [dsc_pkg::COUNT_W-1:0]  match_count,
    input  logic                         pattern_full,
    output int                           mismatches,
    output int                           outstanding
);
    import dsc_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               full;
    } tally_t;

    logic [SYM_W-1:0]   pat [MAX_PATTERN];
    logic [LEN_W-1:0]   plen;
    logic [COUNT_W-1:0] cnt [MAX_PATTERN];
    tally_t             tally_q [$];
    int                 bad = 0;
    int                 waiting = 0;

    assign mismatches  = bad;
    assign outstanding = waiting;

    task automatic flag(input string what, input logic [COUNT_W-1:0] got,
                        input logic [COUNT_W-1:0] want);
        if (bad < 200)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        bad++;
    endtask

    function automatic void zero_counts();
        for (int k = 0; k < MAX_PATTERN; k++)
            cnt[k] = '0;
    endfunction

    // one item through the DP row; descending so each cell sees the old neighbour
    function automatic tally_t apply_item(input logic [MODE_W-1:0] m,
                                          input logic [SYM_W-1:0] s);
        tally_t             res;
        logic [COUNT_W:0]   sum;
        logic [COUNT_W-1:0] below;
        res.full = 1'b0;
        case (m)
            MODE_CLEAR:
            begin
                plen = '0;
                zero_counts();
            end
            MODE_APPEND:
            begin
                if (plen < MAX_PATTERN)
                begin
                    pat[plen[IDX_W-1:0]] = s;
                    plen = plen + 1'b1;
                    zero_counts();
                end
                else
                    res.full = 1'b1;
            end
            MODE_TEXT:
            begin
                for (int k = MAX_PATTERN - 1; k >= 0; k--)
                begin
                    if (k < int'(plen) && pat[k] == s)
                    begin
                        if (k == 0)
                            below = COUNT_W'(1);
                        else
                            below = cnt[k-1];
                        sum = {1'b0, cnt[k]} + {1'b0, below};
                        if (sum >= {1'b0, COUNT_MODULUS})
                            sum = sum - {1'b0, COUNT_MODULUS};
                        cnt[k] = sum[COUNT_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        if (plen == 0)
            res.count = COUNT_W'(1);
        else
            res.count = cnt[IDX_W'(plen - 1'b1)];
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        tally_t want;
        if (!rst_n)
        begin
            plen = '0;
            zero_counts();
            tally_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tally_q.size() == 0)
                    flag("result item with none expected", match_count, '0);
                else
                begin
                    want = tally_q.pop_front();
                    if (match_count !== want.count)
                        flag("match_count", match_count, want.count);
                    if (pattern_full !== want.full)
                        flag("pattern_full", COUNT_W'(pattern_full), COUNT_W'(want.full));
                end
            end
            if (in_valid && in_ready)
                tally_q.push_back(apply_item(mode, symbol));
        end
        waiting <= tally_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the distinct subsequence counter: clock, reset, stimulus,
// result-side stalls, watchdog and verdict. Depends on dsc_pkg, dsc_checker and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import dsc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int ITEMS       = 2000;
    localparam int CALM_TAIL   = 200;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [MODE_W-1:0]  mode = MODE_CLEAR;
    logic [SYM_W-1:0]   symbol = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COUNT_W-1:0] match_count;
    logic               pattern_full;

    int                 mismatches;
    int                 outstanding;
    int                 sent = 0;
    int                 quiet = 0;
    int                 stall_left = 0;
    bit                 calm = 1'b0;
    logic [SYM_W-1:0]   alpha [4];
    int                 alpha_n = 1;

    always #1 clk = ~clk;

    distinct_subsequence_counter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match_count  (match_count),
        .pattern_full (pattern_full)
    );

    dsc_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match_count  (match_count),
        .pattern_full (pattern_full),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // result side stalls in bursts of random length while not calm
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic push_item(input logic [MODE_W-1:0] m, input logic [SYM_W-1:0] s);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        symbol   <= s;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic new_alphabet(input int n);
        alpha_n = n;
        for (int k = 0; k < 4; k++)
            alpha[k] = SYM_W'($urandom);
    endtask

    function automatic logic [SYM_W-1:0] pick_sym(input int pct);
        if ($urandom_range(0, 99) < pct)
            return alpha[$urandom_range(0, alpha_n - 1)];
        return SYM_W'($urandom_range(0, 255));
    endfunction

    task automatic load_pattern(input int len);
        repeat (len) push_item(MODE_APPEND, pick_sym(100));
    endtask

    task automatic feed_text(input int n, input int pct);
        repeat (n) push_item(MODE_TEXT, pick_sym(pct));
    endtask

    initial
    begin
        int  kind;
        bit  paused;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pattern, no-op mode, one and two byte patterns,
        // extreme symbols, filling the store and a refused append
        push_item(MODE_CLEAR, 8'hFF);
        push_item(MODE_TEXT, 8'h00);
        push_item(MODE_NOP, 8'hAA);
        push_item(MODE_APPEND, 8'h00);
        push_item(MODE_TEXT, 8'hFF);
        push_item(MODE_TEXT, 8'h00);
        push_item(MODE_TEXT, 8'h00);
        push_item(MODE_APPEND, 8'hFF);
        push_item(MODE_TEXT, 8'h00);
        push_item(MODE_TEXT, 8'hFF);
        repeat (MAX_PATTERN - 2) push_item(MODE_APPEND, 8'h80);
        push_item(MODE_APPEND, 8'h7F);
        push_item(MODE_TEXT, 8'h80);
        drain();

        while (sent < ITEMS)
        begin
            if (sent >= ITEMS - CALM_TAIL)
                calm = 1'b1;
            if (!paused && sent >= ITEMS / 2)
            begin
                drain();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                new_alphabet($urandom_range(1, 4));
                if ($urandom_range(0, 3) != 0)
                    push_item(MODE_CLEAR, SYM_W'($urandom));
                load_pattern(($urandom_range(0, 7) == 0) ? MAX_PATTERN : $urandom_range(1, 6));
                feed_text($urandom_range(0, 60), 90);
            end
            else if (kind < 72)
            begin
                // long single-symbol run: counts wrap past the modulus
                new_alphabet(1);
                push_item(MODE_CLEAR, SYM_W'($urandom));
                load_pattern(MAX_PATTERN);
                feed_text($urandom_range(100, 160), 100);
            end
            else if (kind < 84)
            begin
                new_alphabet(2);
                push_item(MODE_CLEAR, SYM_W'($urandom));
                load_pattern(MAX_PATTERN + $urandom_range(1, 3));
                feed_text($urandom_range(1, 20), 90);
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                    push_item(MODE_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
